// File: design/hvn2d_pkg.sv
`default_nettype none

package hvn2d_pkg;

  // Field widths.
  localparam int COORD_W = 32;
  localparam int VALUE_W = 31;
  localparam int NOISE_W = 16;

  // Default number of fractional coordinate bits.
  localparam int FRAC_BITS_DEF = 16;

  // Lattice hash constants.
  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
  localparam logic [31:0] HASH_MIX   = 32'd1274126177;
  localparam int          HASH_SHIFT = 13;

  // Number of lattice corners around one point.
  localparam int CORNERS = 4;

endpackage : hvn2d_pkg

`default_nettype wire

// File: design/hashed_value_noise_2d.sv
// Smooth 2D value noise over a hashed integer lattice.
//
// Input channel s_*: one request carries a coordinate pair in signed fixed
// point with FRAC_BITS fractional bits (x in the low word, y in the high word).
// Output channel m_*: one result per request, the noise as an unsigned Q0.16
// fraction. Results leave in request order.
//
// The datapath is a five-stage pipeline: lattice multiplies and t^2, corner
// hash sums with shift-xor and the smoothstep product, the hash mix multiply,
// the x interpolation of both rows, and the y interpolation into the output
// register. One request is accepted every cycle while the receiver keeps up.
//
// Each stage holds its own valid bit and advances when its successor is free,
// so bubbles close up while the receiver stalls and s_tready stays high until
// all five stages are full. A stalled result holds on m_tdata unchanged.
// Reset clears all valid bits; no request is in flight afterwards.

`default_nettype none

module hashed_value_noise_2d
  import hvn2d_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [2*COORD_W-1:0] s_tdata,  // coord_x [31:0], coord_y [63:32]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [NOISE_W-1:0]        m_tdata   // noise_value [15:0]
);

  localparam int F = FRAC_BITS;
  localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;

  // Stage valids and enables.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5      = !v5 || m_tready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign m_tvalid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: floored integer parts, lattice multiplies and t squared.
  logic [COORD_W-1:0] cx, cy, ix, iy;
  logic [31:0]        px_d, py_d;
  logic [F-1:0]       tx_d, ty_d;
  logic [2*F-1:0]     tsqx, tsqy;

  assign cx   = s_tdata[COORD_W-1:0];
  assign cy   = s_tdata[2*COORD_W-1:COORD_W];
  assign ix   = $unsigned($signed(cx) >>> F);
  assign iy   = $unsigned($signed(cy) >>> F);
  assign px_d = ix * HASH_MUL_X;
  assign py_d = iy * HASH_MUL_Y;
  assign tx_d = cx[F-1:0];
  assign ty_d = cy[F-1:0];
  assign tsqx = {{F{1'b0}}, tx_d} * {{F{1'b0}}, tx_d};
  assign tsqy = {{F{1'b0}}, ty_d} * {{F{1'b0}}, ty_d};

  logic [31:0]  px1, py1;
  logic [F-1:0] tx1, ty1, sqx1, sqy1;

  always_ff @(posedge clk) begin
    if (en1) begin
      px1  <= px_d;
      py1  <= py_d;
      tx1  <= tx_d;
      ty1  <= ty_d;
      sqx1 <= tsqx[2*F-1:F];
      sqy1 <= tsqy[2*F-1:F];
    end
  end

  // Stage 2: corner hash sums with shift-xor, and the smoothstep product.
  // Corner order: 0 = (x, y), 1 = (x+1, y), 2 = (x, y+1), 3 = (x+1, y+1).
  logic [31:0] hx_lo, hx_hi, hy_lo, hy_hi;
  logic [31:0] hsum [CORNERS];
  logic [31:0] hmix_d [CORNERS];

  assign hx_lo = px1;
  assign hx_hi = px1 + HASH_MUL_X;
  assign hy_lo = py1;
  assign hy_hi = py1 + HASH_MUL_Y;

  assign hsum[0] = hx_lo + hy_lo;
  assign hsum[1] = hx_hi + hy_lo;
  assign hsum[2] = hx_lo + hy_hi;
  assign hsum[3] = hx_hi + hy_hi;

  for (genvar c = 0; c < CORNERS; c++) begin : g_xorshift
    assign hmix_d[c] = hsum[c] ^ (hsum[c] >> HASH_SHIFT);
  end

  logic [F+1:0]     kx, ky;
  logic [2*F+1:0]   ex, ey;

  assign kx = THREE_ONE - {1'b0, tx1, 1'b0};
  assign ky = THREE_ONE - {1'b0, ty1, 1'b0};
  assign ex = {{(F+2){1'b0}}, sqx1} * {{F{1'b0}}, kx};
  assign ey = {{(F+2){1'b0}}, sqy1} * {{F{1'b0}}, ky};

  logic [31:0]  hmix2 [CORNERS];
  logic [F-1:0] sx2, sy2;

  always_ff @(posedge clk) begin
    if (en2) begin
      hmix2 <= hmix_d;
      sx2   <= ex[2*F-1:F];
      sy2   <= ey[2*F-1:F];
    end
  end

  // Stage 3: final hash multiply; the low 31 bits are the corner values.
  logic [31:0]        hfin [CORNERS];
  logic [VALUE_W-1:0] n3 [CORNERS];
  logic [F-1:0]       sx3, sy3;

  for (genvar c = 0; c < CORNERS; c++) begin : g_mix
    assign hfin[c] = hmix2[c] * HASH_MIX;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int c = 0; c < CORNERS; c++) begin
        n3[c] <= hfin[c][VALUE_W-1:0];
      end
      sx3 <= sx2;
      sy3 <= sy2;
    end
  end

  // Stage 4: interpolate both rows along x as a + ((b - a) * s) >> F.
  logic signed [31:0]  dx0, dx1;
  logic signed [32+F:0] qx0, qx1, shx0, shx1;
  logic [32+F:0]       ax0, ax1;

  assign dx0  = $signed({1'b0, n3[1]}) - $signed({1'b0, n3[0]});
  assign dx1  = $signed({1'b0, n3[3]}) - $signed({1'b0, n3[2]});
  assign qx0  = dx0 * $signed({1'b0, sx3});
  assign qx1  = dx1 * $signed({1'b0, sx3});
  assign shx0 = qx0 >>> F;
  assign shx1 = qx1 >>> F;
  assign ax0  = {{(F+2){1'b0}}, n3[0]} + $unsigned(shx0);
  assign ax1  = {{(F+2){1'b0}}, n3[2]} + $unsigned(shx1);

  logic [VALUE_W-1:0] a0, a1;
  logic [F-1:0]       sy4;

  always_ff @(posedge clk) begin
    if (en4) begin
      a0  <= ax0[VALUE_W-1:0];
      a1  <= ax1[VALUE_W-1:0];
      sy4 <= sy3;
    end
  end

  // Stage 5: interpolate along y and keep the top 16 bits of the Q0.31 value.
  logic signed [31:0]   dy;
  logic signed [32+F:0] qy, shy;
  logic [32+F:0]        ry;

  assign dy  = $signed({1'b0, a1}) - $signed({1'b0, a0});
  assign qy  = dy * $signed({1'b0, sy4});
  assign shy = qy >>> F;
  assign ry  = {{(F+2){1'b0}}, a0} + $unsigned(shy);

  always_ff @(posedge clk) begin
    if (en5) begin
      m_tdata <= ry[VALUE_W-1:VALUE_W-NOISE_W];
    end
  end

endmodule : hashed_value_noise_2d

`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
  import hvn2d_pkg::*;

  localparam int RANDOM_REQUESTS = 1950;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } coord_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [2*COORD_W-1:0] s_tdata = '0;  // coord_x [31:0], coord_y [63:32]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [NOISE_W-1:0] m_tdata;  // noise_value [15:0]

  coord_pair_t coord_queue[$];
  logic [NOISE_W-1:0] noise_expected[$];

  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int wrap_requests = 0;
  int directed_count = 0;
  int send_gap = 0;
  int recv_stall = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int idle_cycles = 0;

  hashed_value_noise_2d uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Corner value of the lattice point (cx, cy), a Q0.31 fraction.
  function automatic logic [63:0] lattice_hash(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] h;
    h = cx * HASH_MUL_X + cy * HASH_MUL_Y;
    h = (h ^ (h >> HASH_SHIFT)) * HASH_MIX;
    return {33'd0, h[VALUE_W-1:0]};
  endfunction

  // Smoothstep of the fractional part, Q0.F in and out.
  function automatic logic [63:0] smooth_ease(logic [31:0] c);
    logic [63:0] one;
    logic [63:0] t;
    logic [63:0] sq;
    one = 64'd1 << FRAC_BITS_DEF;
    t = {32'd0, c} & (one - 64'd1);
    sq = (t * t) >> FRAC_BITS_DEF;
    return (sq * (64'd3 * one - 64'd2 * t)) >> FRAC_BITS_DEF;
  endfunction

  // Linear blend from a to b by weight s, truncated.
  function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    logic [63:0] one;
    one = 64'd1 << FRAC_BITS_DEF;
    return (a * (one - s) + b * s) >> FRAC_BITS_DEF;
  endfunction

  // Integer lattice index: floor of the coordinate, sign-extended.
  function automatic logic [31:0] lattice_index(logic [31:0] c);
    return $signed(c) >>> FRAC_BITS_DEF;
  endfunction

  // Noise for one coordinate pair, as a Q0.16 fraction.
  function automatic logic [NOISE_W-1:0] predict_noise(logic [31:0] x, logic [31:0] y);
    logic [31:0] ix;
    logic [31:0] iy;
    logic [63:0] sx;
    logic [63:0] sy;
    logic [63:0] row_lo;
    logic [63:0] row_hi;
    logic [63:0] r;
    ix = lattice_index(x);
    iy = lattice_index(y);
    sx = smooth_ease(x);
    sy = smooth_ease(y);
    row_lo = blend(lattice_hash(ix, iy), lattice_hash(ix + 32'd1, iy), sx);
    row_hi = blend(lattice_hash(ix, iy + 32'd1), lattice_hash(ix + 32'd1, iy + 32'd1), sx);
    r = blend(row_lo, row_hi, sy);
    return r[30:15];
  endfunction

  // One random coordinate, weighted toward the interesting regions.
  function automatic logic [31:0] random_coord();
    logic [31:0] c;
    logic [15:0] frac;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = $urandom();
      4: begin
        // Integer part within a few cells of the origin.
        c = {16'($signed(5'($urandom_range(0, 31)))), 16'($urandom())};
      end
      5: begin
        // Fraction at its ends or midpoint.
        case ($urandom_range(0, 3))
          0: frac = 16'h0000;
          1: frac = 16'hffff;
          2: frac = 16'h0001;
          default: frac = 16'h8000;
        endcase
        c = {16'($urandom()), frac};
      end
      6: c = {16'hffff, 16'($urandom())};  // upper corner wraps to index zero
      7: begin
        // Integer part at the signed extremes.
        c = {($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000, 16'($urandom())};
      end
      default: c = $urandom();
    endcase
    return c;
  endfunction

  // Gap length: mostly none, sometimes short, rarely long.
  function automatic int draw_gap(bit calm);
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  // Driver: presents queued requests, inserting random gaps between them.
  always @(posedge clk) begin
    coord_pair_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        item = s_tdata;
        noise_expected.insert(noise_expected.size(), predict_noise(item.x, item.y));
        requests_sent++;
        if (item.x[31:16] == 16'hffff || item.y[31:16] == 16'hffff) begin
          wrap_requests++;
        end
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (coord_queue.size() > 0) begin
          item = coord_queue.pop_front();
          s_tdata <= item;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 149) == 0) begin
            send_calm = !send_calm;
          end
          send_gap = draw_gap(send_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result and stalls the output at random.
  always @(posedge clk) begin
    logic [NOISE_W-1:0] want;
    logic ready_next;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (noise_expected.size() == 0) begin
          $error("unexpected result: noise_value %0d with no request outstanding", m_tdata);
          error_count++;
        end else begin
          want = noise_expected.pop_front();
          if (m_tdata !== want) begin
            $error("noise_value mismatch: expected %0d, actual %0d", want, m_tdata);
            error_count++;
          end
          results_checked++;
        end
      end
      ready_next = 1'b1;
      if (recv_stall > 0) begin
        recv_stall--;
        ready_next = 1'b0;
      end else begin
        if ($urandom_range(0, 299) == 0) begin
          recv_calm = !recv_calm;
        end
        if (!recv_calm && $urandom_range(0, 4) == 0) begin
          recv_stall = draw_gap(1'b0);
        end
      end
      m_tready <= ready_next;
    end
  end

  // Watchdog: ends the run if nothing moves while work is pending.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (coord_queue.size() > 0 || s_tvalid || noise_expected.size() > 0) begin
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles.", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    coord_pair_t item;
    // Directed requests: field extremes, fraction ends and lattice wrap.
    coord_queue.insert(coord_queue.size(), '{y: 32'h0000_0000, x: 32'h0000_0000});
    coord_queue.insert(coord_queue.size(), '{y: 32'hffff_ffff, x: 32'hffff_ffff});
    coord_queue.insert(coord_queue.size(), '{y: 32'h8000_0000, x: 32'h8000_0000});
    coord_queue.insert(coord_queue.size(), '{y: 32'h7fff_ffff, x: 32'h7fff_ffff});
    coord_queue.insert(coord_queue.size(), '{y: 32'h7fff_ffff, x: 32'h8000_0000});
    coord_queue.insert(coord_queue.size(), '{y: 32'h8000_0000, x: 32'h7fff_ffff});
    coord_queue.insert(coord_queue.size(), '{y: 32'h0000_ffff, x: 32'h0000_ffff});
    coord_queue.insert(coord_queue.size(), '{y: 32'h0000_8000, x: 32'h0000_8000});
    coord_queue.insert(coord_queue.size(), '{y: 32'h0001_0000, x: 32'h0000_0001});
    coord_queue.insert(coord_queue.size(), '{y: 32'h0000_0000, x: 32'hffff_0000});
    coord_queue.insert(coord_queue.size(), '{y: 32'hffff_c000, x: 32'hffff_8000});
    coord_queue.insert(coord_queue.size(), '{y: 32'hffff_0001, x: 32'h0001_0000});
    coord_queue.insert(coord_queue.size(), '{y: 32'h0000_0000, x: 32'h7fff_0000});
    coord_queue.insert(coord_queue.size(), '{y: 32'h7fff_ffff, x: 32'h0000_0000});
    coord_queue.insert(coord_queue.size(), '{y: 32'h9abc_def0, x: 32'h1234_5678});
    coord_queue.insert(coord_queue.size(), '{y: 32'hfffe_ffff, x: 32'hfffe_0001});
    coord_queue.insert(coord_queue.size(), '{y: 32'h8000_ffff, x: 32'h7fff_0001});
    coord_queue.insert(coord_queue.size(), '{y: 32'h5555_5555, x: 32'haaaa_aaaa});
    coord_queue.insert(coord_queue.size(), '{y: 32'haaaa_aaaa, x: 32'h5555_5555});
    coord_queue.insert(coord_queue.size(), '{y: 32'hffff_ffff, x: 32'h0000_0000});
    directed_count = coord_queue.size();
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      item.x = random_coord();
      item.y = random_coord();
      coord_queue.insert(coord_queue.size(), item);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be accepted and every result to arrive.
    while (coord_queue.size() > 0 || s_tvalid) begin
      @(posedge clk);
    end
    while (noise_expected.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (noise_expected.size() != 0) begin
      $error("%0d expected results never arrived", noise_expected.size());
      error_count++;
    end
    $display("Sent %0d coordinate pairs (%0d directed, %0d random), %0d near the wrap.",
             requests_sent, directed_count, requests_sent - directed_count, wrap_requests);
    $display("Checked %0d noise results with random gaps and output stalls.",
             results_checked);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/hvn2d_pkg.sv
design/hashed_value_noise_2d.sv
tb/tb_top.sv
